>>> hw/rtl/ryuv_pkg.sv
package ryuv_pkg;

   // field and register widths
   localparam int PIX_W         = 8;
   localparam int CFG_W         = 13;
   localparam int CSR_IDX_W     = 1;
   localparam int LUMA_ADDR_W   = 24;
   localparam int CHROMA_PTR_W  = 22;
   localparam int CHROMA_ADDR_W = 25;

   // stream payload widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 104;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd360;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // bt.601 weights scaled by 1000
   localparam int W_Y_R  = 257;
   localparam int W_Y_G  = 504;
   localparam int W_Y_B  = 98;
   localparam int W_U_R  = 439;
   localparam int W_U_G  = -368;
   localparam int W_U_B  = -71;
   localparam int W_V_R  = -148;
   localparam int W_V_G  = -291;
   localparam int W_V_B  = 439;
   localparam int LUMA_OFFSET   = 16;
   localparam int CHROMA_OFFSET = 128;
   localparam int PIX_MAX       = 255;

   // weighted sums stay within +-219045
   localparam int SUM_W = 19;
   localparam int MAG_W = SUM_W - 1;
   localparam int QUO_W = 9;

   // ceil(2^28 / 1000), exact floor division for magnitudes below about 490000
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

   typedef struct packed {
      logic [LUMA_ADDR_W-1:0]  luma_addr;
      logic [CHROMA_PTR_W-1:0] chroma_ptr;
      logic                    chroma_valid;
      logic                    frame_last;
   } pos_type;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [QUO_W-1:0] quo_type;

   function automatic logic [PIX_W-1:0] clamp_pixel(input int v);
      logic [PIX_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > PIX_MAX) begin
         r = PIX_W'(PIX_MAX);
      end else begin
         r = PIX_W'(v);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ryuv_div1000.sv
module ryuv_div1000
   import ryuv_pkg::*;
(
   input  sum_type sum,
   output quo_type quotient
);

   localparam int PROD_W = MAG_W + RECIP_W;

   logic              neg;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [QUO_W-1:0]  quo_mag;

   // truncation toward zero: divide the magnitude, then restore the sign
   assign neg      = sum[SUM_W-1];
   assign mag      = neg ? MAG_W'(-sum) : MAG_W'(sum);
   assign prod     = PROD_W'(mag) * PROD_W'(RECIP_1000);
   assign quo_mag  = QUO_W'(prod >> RECIP_SHIFT);
   assign quotient = neg ? -$signed(quo_mag) : $signed(quo_mag);

endmodule

>>> hw/rtl/ryuv_frame_ctl.sv
module ryuv_frame_ctl
   import ryuv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata,
   input  logic                     step,
   output pos_type                  pos,
   output logic [CHROMA_ADDR_W-1:0] area
);

   localparam int SZW    = $clog2(MAX_WIDTH + 1);
   localparam int SZH    = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int PROD_W = SZW + SZH;

   logic [CFG_W-1:0]        width_ff, height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [LUMA_ADDR_W-1:0]  luma_ptr_ff;
   logic [CHROMA_PTR_W-1:0] chroma_ptr_ff;
   logic [CHROMA_ADDR_W-1:0] area_ff;

   logic [SZW-1:0]    w_sat;
   logic [SZH-1:0]    h_sat;
   logic [PROD_W-1:0] area_full;
   logic              row_end, last, chroma_valid;

   always_comb begin
      if (width_ff < CFG_W'(2)) begin
         w_sat = SZW'(2);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_sat = SZW'(MAX_WIDTH);
      end else begin
         w_sat = SZW'(width_ff);
      end
      if (height_ff < CFG_W'(2)) begin
         h_sat = SZH'(2);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_sat = SZH'(MAX_HEIGHT);
      end else begin
         h_sat = SZH'(height_ff);
      end
   end

   assign row_end      = 32'(col_ff) >= 32'(w_sat) - 32'd1;
   assign last         = row_end && (32'(row_ff) >= 32'(h_sat) - 32'd1);
   assign chroma_valid = !col_ff[0] && !row_ff[0];
   assign area_full    = PROD_W'(w_sat) * PROD_W'(h_sat);

   assign pos.luma_addr    = luma_ptr_ff;
   assign pos.chroma_ptr   = chroma_ptr_ff;
   assign pos.chroma_valid = chroma_valid;
   assign pos.frame_last   = last;
   assign area             = area_ff;

   always_ff @(posedge clock) begin
      area_ff <= CHROMA_ADDR_W'(area_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_FRAME_WIDTH;
         height_ff <= RESET_FRAME_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         luma_ptr_ff   <= '0;
         chroma_ptr_ff <= '0;
      end else if (step) begin
         if (last) begin
            col_ff        <= '0;
            row_ff        <= '0;
            luma_ptr_ff   <= '0;
            chroma_ptr_ff <= '0;
         end else begin
            luma_ptr_ff <= luma_ptr_ff + LUMA_ADDR_W'(1);
            if (chroma_valid) begin
               chroma_ptr_ff <= chroma_ptr_ff + CHROMA_PTR_W'(1);
            end
            if (row_end) begin
               col_ff <= '0;
               row_ff <= row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      step && last |=> col_ff == '0 && row_ff == '0 && luma_ptr_ff == '0
                       && chroma_ptr_ff == '0)
      else $error("frame end did not rewind counters");

   a_luma_advance: assert property (@(posedge clock) disable iff (reset)
      step && !last |=> luma_ptr_ff == $past(luma_ptr_ff) + LUMA_ADDR_W'(1))
      else $error("luma pointer did not advance");

   a_chroma_hold: assert property (@(posedge clock) disable iff (reset)
      step && !last && !chroma_valid |=> $stable(chroma_ptr_ff))
      else $error("chroma pointer moved on a pixel without chroma");

endmodule

>>> hw/rtl/rgb_to_yuv420_planar_core.sv
// rgb to planar yuv 4:2:0 converter with bt.601 weights. one rgb pixel per
// req beat in raster order gives one rsp beat: luma and its byte offset in
// the planar buffer, plus, on even rows and even columns (rsp_tuser high),
// the red-difference and blue-difference chroma values and their offsets in
// the first and second chroma planes, which start at w*h and w*h + w*h/4.
// rsp_tlast marks the last pixel of a frame; counters then restart. frame
// size is set through csr writes (index 0 width, index 1 height), saturated
// to 2..MAX_WIDTH and 2..MAX_HEIGHT, and must only change while idle. the
// block takes one pixel per clock unless rsp_tready back-pressure stalls it;
// each pixel passes the input, weighted-sum and scaled result registers, and
// the reciprocal multiply divides each sum by 1000 between the last two. a
// csr write takes effect for pixels accepted from the next cycle on.
module rgb_to_yuv420_planar_core
   import ryuv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,

   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,

   // pixel input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // red, green, blue

   // converted output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // luma, luma_addr, first_chroma,
                                              // second_chroma, first_chroma_addr,
                                              // second_chroma_addr, zero pad
   output logic                   rsp_tuser,  // chroma_valid
   output logic                   rsp_tlast   // frame_last
);

   localparam int RSP_USED_W = 2 * LUMA_ADDR_W / 3 * 0 + PIX_W + LUMA_ADDR_W
                               + 2 * PIX_W + 2 * CHROMA_ADDR_W;

   // pipeline handshake
   logic s1_ready, s2_ready, out_ready, accept;

   // stage 1: captured pixel and raster position
   logic             s1_v_ff;
   logic [PIX_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   pos_type          s1_pos_ff;
   pos_type          pos;

   // stage 2: weighted sums
   logic    s2_v_ff;
   sum_type y_sum_ff, u_sum_ff, v_sum_ff;
   sum_type y_sum_in, u_sum_in, v_sum_in;
   pos_type s2_pos_ff;

   // output register
   logic                     out_v_ff;
   logic [PIX_W-1:0]         luma_ff, first_ff, second_ff;
   logic [LUMA_ADDR_W-1:0]   luma_addr_ff;
   logic [CHROMA_ADDR_W-1:0] first_addr_ff, second_addr_ff;
   logic                     chroma_valid_ff, frame_last_ff;

   logic [PIX_W-1:0]         luma_in, first_in, second_in;
   logic [CHROMA_ADDR_W-1:0] first_addr_in, second_addr_in;
   logic [CHROMA_ADDR_W-1:0] area;
   quo_type                  y_quo, u_quo, v_quo;

   // each stage moves when the one after it can take its beat
   assign out_ready  = !out_v_ff || rsp_tready;
   assign s2_ready   = !s2_v_ff || out_ready;
   assign s1_ready   = !s1_v_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;

   ryuv_frame_ctl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_frame_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (accept),
      .pos       (pos),
      .area      (area)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_red_ff   <= req_tdata[7:0];
         s1_green_ff <= req_tdata[15:8];
         s1_blue_ff  <= req_tdata[23:16];
         s1_pos_ff   <= pos;
      end
   end

   // constant-weight sums, signed
   assign y_sum_in = SUM_W'(W_Y_R * int'(s1_red_ff) + W_Y_G * int'(s1_green_ff)
                            + W_Y_B * int'(s1_blue_ff));
   assign u_sum_in = SUM_W'(W_U_R * int'(s1_red_ff) + W_U_G * int'(s1_green_ff)
                            + W_U_B * int'(s1_blue_ff));
   assign v_sum_in = SUM_W'(W_V_R * int'(s1_red_ff) + W_V_G * int'(s1_green_ff)
                            + W_V_B * int'(s1_blue_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_v_ff) begin
         y_sum_ff  <= y_sum_in;
         u_sum_ff  <= u_sum_in;
         v_sum_ff  <= v_sum_in;
         s2_pos_ff <= s1_pos_ff;
      end
   end

   // divide by 1000 toward zero
   ryuv_div1000 u_div_y (.sum(y_sum_ff), .quotient(y_quo));
   ryuv_div1000 u_div_u (.sum(u_sum_ff), .quotient(u_quo));
   ryuv_div1000 u_div_v (.sum(v_sum_ff), .quotient(v_quo));

   // offset and clamp; chroma fields read zero off the chroma grid
   always_comb begin
      luma_in        = clamp_pixel(int'(y_quo) + LUMA_OFFSET);
      first_in       = '0;
      second_in      = '0;
      first_addr_in  = '0;
      second_addr_in = '0;
      if (s2_pos_ff.chroma_valid) begin
         first_in       = clamp_pixel(int'(u_quo) + CHROMA_OFFSET);
         second_in      = clamp_pixel(int'(v_quo) + CHROMA_OFFSET);
         first_addr_in  = area + CHROMA_ADDR_W'(s2_pos_ff.chroma_ptr);
         second_addr_in = area + (area >> 2) + CHROMA_ADDR_W'(s2_pos_ff.chroma_ptr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_v_ff) begin
         luma_ff         <= luma_in;
         luma_addr_ff    <= s2_pos_ff.luma_addr;
         first_ff        <= first_in;
         second_ff       <= second_in;
         first_addr_ff   <= first_addr_in;
         second_addr_ff  <= second_addr_in;
         chroma_valid_ff <= s2_pos_ff.chroma_valid;
         frame_last_ff   <= s2_pos_ff.frame_last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), second_addr_ff, first_addr_ff,
                        second_ff, first_ff, luma_addr_ff, luma_ff};
   assign rsp_tuser  = chroma_valid_ff;
   assign rsp_tlast  = frame_last_ff;

   a_no_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[97:32] == '0)
      else $error("chroma fields not cleared off the chroma grid");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !s1_v_ff |-> req_tready)
      else $error("empty input stage refused a beat");

   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !out_ready |=> s2_v_ff && $stable(y_sum_ff) && $stable(s2_pos_ff))
      else $error("stage 2 beat lost under back-pressure");

endmodule

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ryuv_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int LATENCY      = 3;         // req beat to rsp beat
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_LIMIT  = 5000;      // cycles to wait for outstanding beats
   localparam int LONG_HOLD    = 200;       // receiver hold-off in the pressure test

   // rsp_tdata field positions, lowest first
   localparam int LUMA_LSB  = 0;
   localparam int LADDR_LSB = LUMA_LSB + PIX_W;
   localparam int FCH_LSB   = LADDR_LSB + LUMA_ADDR_W;
   localparam int SCH_LSB   = FCH_LSB + PIX_W;
   localparam int FADDR_LSB = SCH_LSB + PIX_W;
   localparam int SADDR_LSB = FADDR_LSB + CHROMA_ADDR_W;

   typedef enum int {RSP_ALWAYS, RSP_CHOPPY, RSP_SPARSE} rsp_style_type;

   // one converted pixel as the block should report it
   typedef struct {
      logic [PIX_W-1:0]         luma;
      logic [LUMA_ADDR_W-1:0]   luma_addr;
      logic                     chroma_valid;
      logic [PIX_W-1:0]         first_chroma;
      logic [PIX_W-1:0]         second_chroma;
      logic [CHROMA_ADDR_W-1:0] first_addr;
      logic [CHROMA_ADDR_W-1:0] second_addr;
      logic                     frame_last;
   } yuv_beat_type;

   // every block input known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_FRAME_WIDTH;
   logic [CFG_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // red, green, blue
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // luma, luma_addr, first_chroma,
                                              // second_chroma, first_chroma_addr,
                                              // second_chroma_addr, zero pad
   logic                  rsp_tuser;          // chroma_valid
   logic                  rsp_tlast;          // frame_last

   // converter state mirrored by the predictor
   logic [CFG_W-1:0]         cfg_width  = RESET_FRAME_WIDTH;
   logic [CFG_W-1:0]         cfg_height = RESET_FRAME_HEIGHT;
   logic [11:0]              col_pos    = '0;
   logic [11:0]              row_pos    = '0;
   logic [LUMA_ADDR_W-1:0]   luma_ptr   = '0;
   logic [CHROMA_PTR_W-1:0]  chroma_ptr = '0;

   yuv_beat_type pending_yuv[$];
   int           mismatch_count  = 0;
   int           frames_finished = 0;
   int           random_sent     = 0;

   // sender and receiver behavior knobs
   bit            sender_bursty = 1'b0;
   int            burst_left    = 0;
   rsp_style_type rsp_style     = RSP_ALWAYS;
   int            hold_request  = 0;
   int            hold_left     = 0;
   int            run_left      = 0;
   bit            ready_phase   = 1'b0;

   rgb_to_yuv420_planar_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // size register saturated to the range the block supports
   function automatic int clip_size(logic [CFG_W-1:0] v, int max_size);
      int s;
      s = int'(v);
      if (s < 2) begin
         s = 2;
      end else if (s > max_size) begin
         s = max_size;
      end
      return s;
   endfunction

   // divide by 1000 toward zero, add offset, clamp to a byte
   function automatic logic [PIX_W-1:0] scale_and_clamp(int weighted, int offset);
      int q;
      q = weighted / 1000 + offset;
      if (q < 0) begin
         q = 0;
      end else if (q > PIX_MAX) begin
         q = PIX_MAX;
      end
      return q[PIX_W-1:0];
   endfunction

   // work out the beat for one accepted pixel and advance the raster position
   function automatic void predict_yuv_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                             logic [PIX_W-1:0] b);
      yuv_beat_type beat;
      int           eff_w;
      int           eff_h;
      longint       area;
      bit           row_end;
      bit           frame_end;
      eff_w     = clip_size(cfg_width, DEF_MAX_WIDTH);
      eff_h     = clip_size(cfg_height, DEF_MAX_HEIGHT);
      area      = longint'(eff_w) * longint'(eff_h);
      // a column or row beyond the size, after a size change, ends the row or frame
      row_end   = int'(col_pos) >= eff_w - 1;
      frame_end = row_end && (int'(row_pos) >= eff_h - 1);

      beat.luma = scale_and_clamp(W_Y_R * int'(r) + W_Y_G * int'(g) + W_Y_B * int'(b),
                                  LUMA_OFFSET);
      beat.luma_addr    = luma_ptr;
      beat.chroma_valid = !col_pos[0] && !row_pos[0];
      beat.first_chroma  = '0;
      beat.second_chroma = '0;
      beat.first_addr    = '0;
      beat.second_addr   = '0;
      if (beat.chroma_valid) begin
         // first plane carries the red-difference weights
         beat.first_chroma  = scale_and_clamp(W_U_R * int'(r) + W_U_G * int'(g)
                                              + W_U_B * int'(b), CHROMA_OFFSET);
         beat.second_chroma = scale_and_clamp(W_V_R * int'(r) + W_V_G * int'(g)
                                              + W_V_B * int'(b), CHROMA_OFFSET);
         beat.first_addr    = CHROMA_ADDR_W'(area + longint'(chroma_ptr));
         beat.second_addr   = CHROMA_ADDR_W'(area + area / 4 + longint'(chroma_ptr));
         chroma_ptr         = chroma_ptr + CHROMA_PTR_W'(1);
      end
      beat.frame_last = frame_end;
      pending_yuv.push_back(beat);

      luma_ptr = luma_ptr + LUMA_ADDR_W'(1);
      if (frame_end) begin
         col_pos    = '0;
         row_pos    = '0;
         luma_ptr   = '0;
         chroma_ptr = '0;
         frames_finished++;
      end else if (row_end) begin
         col_pos = '0;
         row_pos = row_pos + 12'd1;
      end else begin
         col_pos = col_pos + 12'd1;
      end
   endfunction

   // ---------------------------------------------------------------- checker

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // compare each rsp beat with the oldest expected pixel
   always @(posedge clock) begin : check_rsp
      yuv_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_yuv.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual %0h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_yuv.pop_front();
            check_field("luma", 32'(want.luma), 32'(rsp_tdata[LUMA_LSB +: PIX_W]));
            check_field("luma_addr", 32'(want.luma_addr),
                        32'(rsp_tdata[LADDR_LSB +: LUMA_ADDR_W]));
            check_field("chroma_valid", 32'(want.chroma_valid), 32'(rsp_tuser));
            check_field("first_chroma", 32'(want.first_chroma),
                        32'(rsp_tdata[FCH_LSB +: PIX_W]));
            check_field("second_chroma", 32'(want.second_chroma),
                        32'(rsp_tdata[SCH_LSB +: PIX_W]));
            check_field("first_chroma_addr", 32'(want.first_addr),
                        32'(rsp_tdata[FADDR_LSB +: CHROMA_ADDR_W]));
            check_field("second_chroma_addr", 32'(want.second_addr),
                        32'(rsp_tdata[SADDR_LSB +: CHROMA_ADDR_W]));
            check_field("frame_last", 32'(want.frame_last), 32'(rsp_tlast));
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // rsp_tready pattern: run lengths of ready and stall, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_style == RSP_ALWAYS) begin
         rsp_tready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            ready_phase = !ready_phase;
            if (ready_phase) begin
               run_left = (rsp_style == RSP_CHOPPY) ? $urandom_range(1, 12)
                                                    : $urandom_range(1, 3);
            end else begin
               run_left = (rsp_style == RSP_CHOPPY) ? $urandom_range(1, 4)
                                                    : $urandom_range(1, 10);
            end
         end
         run_left--;
         rsp_tready <= ready_phase;
      end
   end

   // ---------------------------------------------------------------- sender

   // offer one pixel, wait for the beat, then record what it should produce
   task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      int gap;
      if (sender_bursty) begin
         // end of a burst: drop valid for a random gap
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      predict_yuv_pixel(r, g, b);
   endtask

   // random colors, with saturated components now and then
   task automatic send_random_pixel();
      logic [PIX_W-1:0] c[3];
      foreach (c[i]) begin
         if ($urandom_range(0, 7) == 0) begin
            c[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else begin
            c[i] = PIX_W'($urandom_range(0, PIX_MAX));
         end
      end
      send_pixel(c[0], c[1], c[2]);
      random_sent++;
   endtask

   // stop offering and wait until every expected beat has come out
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_yuv.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_yuv.size() != 0) begin
         $display("%0t: %0d beats expected actual none", $time, pending_yuv.size());
         mismatch_count += pending_yuv.size();
         pending_yuv.delete();
      end
      // let the pipeline settle before touching the registers
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_FRAME_WIDTH) begin
         cfg_width = value;
      end else begin
         cfg_height = value;
      end
   endtask

   task automatic set_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      drain_results();
      write_csr(REG_FRAME_WIDTH, w);
      write_csr(REG_FRAME_HEIGHT, h);
   endtask

   // ---------------------------------------------------------------- tests

   // color extremes at the reset size, including sums that truncate toward zero
   task automatic test_color_extremes();
      rsp_style = RSP_CHOPPY;
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h01, 8'h00);   // small negative chroma sums
      send_pixel(8'h00, 8'h01, 8'h00);
      send_pixel(8'h01, 8'h00, 8'h01);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      drain_results();
   endtask

   // smallest frame, odd size, out-of-range sizes
   task automatic test_frame_sizes();
      // zero and one saturate up to 2x2
      set_frame_size(13'd0, 13'd1);
      repeat (4) send_random_pixel();
      // odd width: parity still follows the column counter
      set_frame_size(13'd3, 13'd2);
      repeat (6) send_random_pixel();
      // oversized values saturate to the maximum, widest addresses
      set_frame_size(13'd8191, 13'd4097);
      repeat (3) send_random_pixel();
   endtask

   // receiver holds off long enough for the block to back up into req_tready
   task automatic test_backpressure();
      set_frame_size(13'd8, 13'd4);
      sender_bursty = 1'b0;
      rsp_style     = RSP_ALWAYS;
      @(posedge clock);
      hold_request = LONG_HOLD;
      repeat (80) send_random_pixel();
      // sender pauses until every result is back
      drain_results();
   endtask

   // random sizes, mostly whole small frames, with random idling on both sides
   task automatic test_random_frames();
      int sel;
      int w;
      int h;
      int goal;
      while (random_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         case (sel)
            0: begin
               // huge frame: only a partial run, size changes mid-frame afterwards
               w = $urandom_range(0, 1) ? 4096 : $urandom_range(2, 8);
               h = (w == 4096) ? $urandom_range(2, 8191) : 8191;
            end
            1: begin
               w = 2 * $urandom_range(1, 4) + 1;
               h = 2 * $urandom_range(1, 3) + 1;
            end
            2: begin
               w = $urandom_range(0, 2);
               h = $urandom_range(0, 2);
            end
            default: begin
               w = 2 * $urandom_range(1, 8);
               h = 2 * $urandom_range(1, 4);
            end
         endcase
         set_frame_size(CFG_W'(w), CFG_W'(h));
         sender_bursty = $urandom_range(0, 3) != 0;
         burst_left    = 0;
         case ($urandom_range(0, 3))
            0:       rsp_style = RSP_ALWAYS;
            1:       rsp_style = RSP_SPARSE;
            default: rsp_style = RSP_CHOPPY;
         endcase
         if (sel == 0) begin
            repeat ($urandom_range(16, 48)) send_random_pixel();
         end else begin
            goal = frames_finished + $urandom_range(1, 3);
            while (frames_finished < goal) send_random_pixel();
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_frame_sizes();
      test_backpressure();
      test_random_frames();
      drain_results();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
